>>> src/trns_pkg.sv
package trns_pkg;

  // Width of one task handle
  localparam int TASK_W = 16;
  localparam int LEN_W  = 7;

  // Request opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_STEAL = 2'd2;

  // Where a handed-out task goes
  localparam logic [1:0] DEST_CALLER = 2'd0;
  localparam logic [1:0] DEST_GLOBAL = 2'd1;
  localparam logic [1:0] DEST_THIEF  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TASK_W-1:0] task_handle;
    logic              to_next_slot;
    logic              steal_next_too;
  } req_t;

  typedef struct packed {
    logic              task_present;
    logic [TASK_W-1:0] task_out;
    logic [1:0]        destination;
    logic              last_of_run;
    logic [LEN_W-1:0]  queue_length;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the request word
    logic decide;  // apply the request, start a batch or emit its single word
    logic pop;     // emit the ring task already read, fetch the next
    logic tail;    // emit the task that did not fit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;      // output register can take a word this cycle
    logic pops;          // the request reads tasks out of the ring
    logic more;          // ring reads still to issue
    logic tail_pending;  // overflow batch ends with the rejected task
  } status_t;

endpackage

>>> src/task_ring_with_next_slot.sv
// Channel  Handshake              Word
// req      req_valid / req_stall  trns_pkg::req_t: opcode, task_handle, flags
// res      res_valid / res_stall  trns_pkg::res_t: task, destination, last, length
//
// One request at a time: a word is latched in S_IDLE and decided in S_DECIDE
// once the output register is free. A ring read (get from the ring head, steal,
// full-ring put) goes through the registered RAM read, then one task leaves per
// cycle while res_stall is low, plus the task that did not fit. res_stall
// holds the output word, and the next request is taken while it waits. Reset
// (rst, synchronous) empties the ring and the next slot; ring contents stay.
module task_ring_with_next_slot #(
  parameter int RING_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  trns_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output trns_pkg::res_t res
);

  trns_pkg::cmd_t    cmd;
  trns_pkg::status_t st;

  trns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  trns_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req_in    (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_out   (res)
  );

endmodule

>>> src/trns_ram.sv
module trns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a registered read that holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/trns_ctrl.sv
module trns_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  trns_pkg::status_t  st,
  output trns_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_TAIL
  } state_t;

  state_t state;

  // Take a request word only between requests
  assign req_stall = (state != S_IDLE);

  // Commands follow the state and the datapath status
  always_comb begin
    cmd        = '0;
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.decide = (state == S_DECIDE) && st.out_free;
    cmd.pop    = (state == S_POP) && st.out_free;
    cmd.tail   = (state == S_TAIL) && st.out_free;
  end

  // Sequence one request at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (st.out_free) begin
            state <= st.pops ? S_POP : S_IDLE;
          end
        end
        S_POP: begin
          if (st.out_free && !st.more) begin
            state <= st.tail_pending ? S_TAIL : S_IDLE;
          end
        end
        S_TAIL: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/trns_dp.sv
module trns_dp #(
  parameter int RING_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  trns_pkg::cmd_t    cmd,
  output trns_pkg::status_t st,
  input  trns_pkg::req_t    req_in,
  output logic              res_valid,
  input  logic              res_stall,
  output trns_pkg::res_t    res_out
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(2 * RING_DEPTH);
  localparam int OW   = $clog2(RING_DEPTH + 1);
  localparam int LW   = $clog2(RING_DEPTH + 2);
  localparam int HALF = RING_DEPTH / 2;

  localparam int TW = trns_pkg::TASK_W;
  localparam int NW = trns_pkg::LEN_W;

  // Request and queue state
  trns_pkg::req_t req;
  logic [CW-1:0]  rd_cnt;
  logic [CW-1:0]  wr_cnt;
  logic           nxt_full;
  logic [TW-1:0]  nxt_task;
  logic [OW-1:0]  remaining;
  logic           tail_pending;
  logic [TW-1:0]  tail_task;
  logic [1:0]     pop_dest;
  logic [LW-1:0]  len;
  trns_pkg::res_t res_word;

  // Decision terms
  logic [CW:0]   occ_wide;
  logic [OW-1:0] occ;
  logic          is_put;
  logic          is_get;
  logic          is_steal;
  logic          full;
  logic          fill_next;
  logic [TW-1:0] put_task;
  logic          ring_write;
  logic          overflow;
  logic          get_next;
  logic          get_ring;
  logic          steal_ring;
  logic          steal_next;
  logic [OW-1:0] half_up;
  logic [OW-1:0] n_pop;
  logic          nf_after;
  logic [LW-1:0] len_after;
  logic          single_present;
  logic [1:0]    single_dest;
  logic          pops;
  logic          more;

  // Memory ports
  logic          ram_we;
  logic          ram_re;
  logic [TW-1:0] ram_rdata;
  logic          out_free;
  logic          load;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    bump = (c == CW'(2 * RING_DEPTH - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot(input logic [CW-1:0] c);
    slot = (c >= CW'(RING_DEPTH)) ? AW'(c - CW'(RING_DEPTH)) : AW'(c);
  endfunction

  // Ring occupancy from counters running modulo twice the depth
  always_comb begin
    if (wr_cnt >= rd_cnt) begin
      occ_wide = {1'b0, wr_cnt} - {1'b0, rd_cnt};
    end else begin
      occ_wide = {1'b0, wr_cnt} + (CW + 1)'(2 * RING_DEPTH) - {1'b0, rd_cnt};
    end
    occ = OW'(occ_wide);
  end

  // Classify the latched request against the current queue
  always_comb begin
    is_put     = (req.opcode == trns_pkg::OP_PUT);
    is_get     = (req.opcode == trns_pkg::OP_GET);
    is_steal   = (req.opcode == trns_pkg::OP_STEAL);
    full       = (occ == OW'(RING_DEPTH));
    fill_next  = is_put && req.to_next_slot && !nxt_full;
    put_task   = (req.to_next_slot && nxt_full) ? nxt_task : req.task_handle;
    ring_write = is_put && !fill_next && !full;
    overflow   = is_put && !fill_next && full;
    get_next   = is_get && nxt_full;
    get_ring   = is_get && !nxt_full && (occ != '0);
    steal_ring = is_steal && (occ != '0);
    steal_next = is_steal && (occ == '0) && req.steal_next_too && nxt_full;
    half_up    = occ - (occ >> 1);

    priority if (overflow) begin
      n_pop = OW'(HALF);
    end else if (get_ring) begin
      n_pop = OW'(1);
    end else if (steal_ring) begin
      n_pop = half_up;
    end else begin
      n_pop = '0;
    end
    pops = (n_pop != '0);

    priority if (is_put && req.to_next_slot) begin
      nf_after = 1'b1;
    end else if (get_next || steal_next) begin
      nf_after = 1'b0;
    end else begin
      nf_after = nxt_full;
    end

    len_after = LW'(occ) + LW'(ring_write) - LW'(n_pop) + LW'(nf_after);

    single_present = get_next || steal_next;
    single_dest    = is_steal ? trns_pkg::DEST_THIEF : trns_pkg::DEST_CALLER;
  end

  assign more     = (remaining != '0);
  assign out_free = !res_valid || !res_stall;
  assign load     = (cmd.decide && !pops) || cmd.pop || cmd.tail;
  assign ram_we   = cmd.decide && ring_write;
  assign ram_re   = (cmd.decide && pops) || (cmd.pop && more);

  always_comb begin
    st              = '0;
    st.out_free     = out_free;
    st.pops         = pops;
    st.more         = more;
    st.tail_pending = tail_pending;
  end

  trns_ram #(
    .WIDTH (TW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot(wr_cnt)),
    .wdata (put_task),
    .re    (ram_re),
    .raddr (slot(rd_cnt)),
    .rdata (ram_rdata)
  );

  // Counters, next-slot flag, batch control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt       <= '0;
      wr_cnt       <= '0;
      nxt_full     <= 1'b0;
      remaining    <= '0;
      tail_pending <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_cnt <= bump(rd_cnt);
      end
      if (ram_we) begin
        wr_cnt <= bump(wr_cnt);
      end
      if (cmd.decide) begin
        nxt_full     <= nf_after;
        tail_pending <= overflow;
        if (pops) begin
          remaining <= n_pop - 1'b1;
        end
      end
      if (cmd.pop && more) begin
        remaining <= remaining - 1'b1;
      end
      if (cmd.tail) begin
        tail_pending <= 1'b0;
      end
      // Hold the word until taken
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= req_in;
    end
    if (cmd.decide) begin
      len       <= len_after;
      tail_task <= put_task;
      pop_dest  <= overflow ? trns_pkg::DEST_GLOBAL
                 : (is_steal ? trns_pkg::DEST_THIEF : trns_pkg::DEST_CALLER);
      if (is_put && req.to_next_slot) begin
        nxt_task <= req.task_handle;
      end
    end

    priority if (cmd.decide && !pops) begin
      res_word.task_present <= single_present;
      res_word.task_out     <= single_present ? nxt_task : '0;
      res_word.destination  <= single_dest;
      res_word.last_of_run  <= 1'b1;
      res_word.queue_length <= NW'(len_after);
    end else if (cmd.pop) begin
      res_word.task_present <= 1'b1;
      res_word.task_out     <= ram_rdata;
      res_word.destination  <= pop_dest;
      res_word.last_of_run  <= !more && !tail_pending;
      res_word.queue_length <= NW'(len);
    end else if (cmd.tail) begin
      res_word.task_present <= 1'b1;
      res_word.task_out     <= tail_task;
      res_word.destination  <= trns_pkg::DEST_GLOBAL;
      res_word.last_of_run  <= 1'b1;
      res_word.queue_length <= NW'(len);
    end else begin
      res_word <= res_word;
    end
  end

  assign res_out = res_word;

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = 64;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int SETTLE = 8;
  localparam int TW     = trns_pkg::TASK_W;
  localparam int NW     = trns_pkg::LEN_W;

  // Opcode that the block must answer without touching its state
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  trns_pkg::req_t req;
  logic res_valid;
  logic res_stall;
  trns_pkg::res_t res;

  task_ring_with_next_slot #(.RING_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #10 clk = ~clk;

  // Shadow copy of the run queue
  logic [TW-1:0]    ring_copy [DEPTH];
  logic [CNT_W-1:0] head_cnt = '0;
  logic [CNT_W-1:0] tail_cnt = '0;
  logic             next_full = 1'b0;
  logic [TW-1:0]    next_handle = '0;

  // Result words still owed by the block, oldest first
  trns_pkg::res_t owed_words[$];

  bit quiet;
  bit valid_up;
  int n_items;
  int n_words;
  int n_global;
  int n_thief;
  int errors;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CNT_W-1:0] ring_fill();
    return tail_cnt - head_cnt;
  endfunction

  function automatic logic [TW-1:0] take_head();
    logic [TW-1:0] t;
    t = ring_copy[head_cnt[SLOT_W-1:0]];
    head_cnt = head_cnt + 1'b1;
    return t;
  endfunction

  function automatic trns_pkg::res_t word_of(logic present, logic [TW-1:0] t,
                                             logic [1:0] dest);
    trns_pkg::res_t w;
    w = '0;
    w.task_present = present;
    w.task_out     = present ? t : '0;
    w.destination  = dest;
    return w;
  endfunction

  function automatic trns_pkg::req_t mk_req(logic [1:0] op, logic [TW-1:0] h,
                                            logic nx, logic st);
    trns_pkg::req_t w;
    w.opcode         = op;
    w.task_handle    = h;
    w.to_next_slot   = nx;
    w.steal_next_too = st;
    return w;
  endfunction

  // Apply one request to the shadow queue and queue up the words it owes
  function automatic void predict_run(trns_pkg::req_t w);
    trns_pkg::res_t   run[$];
    logic [TW-1:0]    spill;
    logic             into_ring;
    logic [CNT_W-1:0] fill;
    int               n;
    logic [NW-1:0]    qlen;
    spill     = w.task_handle;
    into_ring = 1'b1;
    case (w.opcode)
      trns_pkg::OP_PUT: begin
        if (w.to_next_slot) begin
          if (!next_full) begin
            next_full = 1'b1;
            into_ring = 1'b0;
          end else begin
            spill = next_handle;
          end
          next_handle = w.task_handle;
        end
        if (!into_ring) begin
          run.push_back(word_of(1'b0, '0, trns_pkg::DEST_CALLER));
        end else if (ring_fill() < DEPTH) begin
          ring_copy[tail_cnt[SLOT_W-1:0]] = spill;
          tail_cnt = tail_cnt + 1'b1;
          run.push_back(word_of(1'b0, '0, trns_pkg::DEST_CALLER));
        end else begin
          // ring full: oldest half plus the task that did not fit go global
          n = int'(ring_fill()) / 2;
          repeat (n) run.push_back(word_of(1'b1, take_head(), trns_pkg::DEST_GLOBAL));
          run.push_back(word_of(1'b1, spill, trns_pkg::DEST_GLOBAL));
          n_global += n + 1;
        end
      end
      trns_pkg::OP_GET: begin
        if (next_full) begin
          next_full = 1'b0;
          run.push_back(word_of(1'b1, next_handle, trns_pkg::DEST_CALLER));
        end else if (ring_fill() != 0) begin
          run.push_back(word_of(1'b1, take_head(), trns_pkg::DEST_CALLER));
        end else begin
          run.push_back(word_of(1'b0, '0, trns_pkg::DEST_CALLER));
        end
      end
      trns_pkg::OP_STEAL: begin
        fill = ring_fill();
        n    = int'(fill) - int'(fill) / 2;
        if (n == 0) begin
          if (w.steal_next_too && next_full) begin
            next_full = 1'b0;
            run.push_back(word_of(1'b1, next_handle, trns_pkg::DEST_THIEF));
            n_thief++;
          end else begin
            run.push_back(word_of(1'b0, '0, trns_pkg::DEST_THIEF));
          end
        end else begin
          repeat (n) run.push_back(word_of(1'b1, take_head(), trns_pkg::DEST_THIEF));
          n_thief += n;
        end
      end
      default: begin
        run.push_back(word_of(1'b0, '0, trns_pkg::DEST_CALLER));
      end
    endcase
    qlen = NW'(ring_fill()) + NW'(next_full);
    foreach (run[i]) begin
      run[i].queue_length = qlen;
      run[i].last_of_run  = (i == run.size() - 1);
      owed_words.push_back(run[i]);
    end
  endfunction

  // Offer one request word, hold it until taken, then predict its results
  task automatic send_word(trns_pkg::req_t w);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0 && valid_up) begin
      req_valid <= 1'b0;
      valid_up = 1'b0;
    end
    repeat (gap) @(posedge clk);
    req_valid <= 1'b1;
    req       <= w;
    valid_up = 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predict_run(w);
    n_items++;
  endtask

  // Stop offering and wait for every owed word, then let the block settle
  task automatic wait_drain(int settle);
    if (valid_up) begin
      req_valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (owed_words.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_word(mk_req(trns_pkg::OP_GET, 16'h0000, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_STEAL, 16'h0000, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_STEAL, 16'hFFFF, 1'b1, 1'b1));
    send_word(mk_req(OP_SPARE, 16'hFFFF, 1'b1, 1'b1));
  endtask

  task automatic test_next_slot();
    // next slot alone: a steal takes it only when asked
    send_word(mk_req(trns_pkg::OP_PUT, 16'hFFFF, 1'b1, 1'b0));
    send_word(mk_req(trns_pkg::OP_STEAL, 16'h0000, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_STEAL, 16'h0000, 1'b0, 1'b1));
    // displaced occupant falls into the ring
    send_word(mk_req(trns_pkg::OP_PUT, 16'h0000, 1'b1, 1'b0));
    send_word(mk_req(trns_pkg::OP_PUT, 16'h1234, 1'b1, 1'b1));
    send_word(mk_req(trns_pkg::OP_GET, 16'h0000, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_GET, 16'h0000, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_GET, 16'h0000, 1'b0, 1'b0));
    // with a ring task present the steal leaves the next slot alone
    send_word(mk_req(trns_pkg::OP_PUT, 16'hA5A5, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_PUT, 16'h5A5A, 1'b1, 1'b0));
    send_word(mk_req(trns_pkg::OP_STEAL, 16'h0000, 1'b0, 1'b1));
    send_word(mk_req(OP_SPARE, 16'h0F0F, 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_GET, 16'h0000, 1'b0, 1'b0));
  endtask

  task automatic test_steal_halves();
    repeat (3)
      send_word(mk_req(trns_pkg::OP_PUT, 16'($urandom_range(0, 65535)), 1'b0, 1'b0));
    repeat (3) send_word(mk_req(trns_pkg::OP_STEAL, 16'h0000, 1'b0, 1'b0));
  endtask

  task automatic test_ring_overflow();
    for (int rep = 0; rep < 2; rep++) begin
      while (ring_fill() < DEPTH)
        send_word(mk_req(trns_pkg::OP_PUT, 16'($urandom_range(0, 65535)),
                         $urandom_range(0, 4) == 0, 1'($urandom)));
      // second round spills the old next-slot task instead of the new one
      if (rep == 1 && !next_full)
        send_word(mk_req(trns_pkg::OP_PUT, 16'($urandom_range(0, 65535)), 1'b1, 1'b0));
      if (rep == 1)
        while (ring_fill() < DEPTH)
          send_word(mk_req(trns_pkg::OP_PUT, 16'($urandom_range(0, 65535)), 1'b0, 1'b0));
      send_word(mk_req(trns_pkg::OP_PUT, 16'($urandom_range(0, 65535)), 1'(rep),
                       1'($urandom)));
    end
    // hold off until both batches have drained
    wait_drain(SETTLE);
    while (ring_fill() != 0)
      send_word(mk_req(trns_pkg::OP_STEAL, 16'($urandom_range(0, 65535)), 1'b0, 1'b0));
    send_word(mk_req(trns_pkg::OP_STEAL, 16'h0000, 1'b0, 1'b1));
    send_word(mk_req(trns_pkg::OP_GET, 16'h0000, 1'b0, 1'b0));
  endtask

  task automatic test_random_mix(int count);
    int         r;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= 30 && i < 50);
      if (i == 60) wait_drain(SETTLE);
      r  = $urandom_range(0, 99);
      op = (r < 48) ? trns_pkg::OP_PUT : (r < 78) ? trns_pkg::OP_GET
         : (r < 97) ? trns_pkg::OP_STEAL : OP_SPARE;
      send_word(mk_req(op, 16'($urandom_range(0, 65535)),
                       $urandom_range(0, 3) == 0, 1'($urandom)));
    end
    quiet = 1'b0;
  endtask

  // Random stall on the result side, in runs of mixed length
  initial begin
    int   run_len;
    logic hold;
    res_stall <= 1'b0;
    forever begin
      hold    = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      run_len = pick_gap() + 1;
      repeat (run_len) begin
        @(posedge clk);
        res_stall <= hold;
      end
    end
  end

  task automatic note_field(string fld, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s expected %0h got %0h", $time, fld, want_v, got_v);
      errors++;
    end
  endtask

  // Compare each accepted result word with the oldest owed word
  always @(posedge clk) begin
    trns_pkg::res_t want;
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      n_words++;
      if (owed_words.size() == 0) begin
        $display("%0t ns: unexpected result word %h", $time, res);
        errors++;
      end else begin
        want = owed_words.pop_front();
        note_field("task_present", 32'(want.task_present), 32'(res.task_present));
        note_field("task_out", 32'(want.task_out), 32'(res.task_out));
        note_field("destination", 32'(want.destination), 32'(res.destination));
        note_field("last_of_run", 32'(want.last_of_run), 32'(res.last_of_run));
        note_field("queue_length", 32'(want.queue_length), 32'(res.queue_length));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("[task_ring_with_next_slot] ERROR");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_next_slot();
    test_steal_halves();
    test_ring_overflow();
    test_random_mix(70);
    wait_drain(SETTLE);

    $display("Sent %0d request words and checked %0d result words;", n_items, n_words);
    $display("%0d tasks went to the global queue and %0d to thieves.", n_global, n_thief);
    if (errors == 0) begin
      $display("[task_ring_with_next_slot] OK");
    end else begin
      $display("[task_ring_with_next_slot] ERROR");
    end
    $finish;
  end

endmodule
